### src/gfbs_pkg.sv
// Shared types and constants for the grouped free-block stack.
`timescale 1ns / 1ps

package gfbs_pkg;

   // Fixed field widths.
   localparam int BLK_W    = 12;
   localparam int STATUS_W = 2;

   // Request codes.
   localparam logic REQ_FREE  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request being transferred
      logic execute;   // apply the request and load the result register
      logic load;      // copy the group row read into the stack
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;  // result register can take a new result this cycle
      logic reload;    // captured request needs a group row reload
   } sts_type;

endpackage

### src/gfbs_ctrl.sv
// Controller state machine for the grouped free-block stack.
`timescale 1ns / 1ps

module gfbs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gfbs_pkg::sts_type sts,
   output gfbs_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD
   } state_type;

   state_type state_ff;
   logic      stall_ff;

   // Sequencing of one request: capture, execute, optional reload.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !stall_ff) begin
                  state_ff <= S_EXEC;
                  stall_ff <= 1'b1;
               end
            end
            S_EXEC: begin
               if (sts.out_free) begin
                  if (sts.reload) begin
                     state_ff <= S_LOAD;
                  end else begin
                     state_ff <= S_IDLE;
                     stall_ff <= 1'b0;
                  end
               end
            end
            S_LOAD: begin
               state_ff <= S_IDLE;
               stall_ff <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall   = stall_ff;

   // Commands decoded from the current state.
   assign cmd.capture = (state_ff == S_IDLE) && req_valid && !stall_ff;
   assign cmd.execute = (state_ff == S_EXEC) && sts.out_free;
   assign cmd.load    = (state_ff == S_LOAD);

endmodule

### src/gfbs_dp.sv
// Datapath: in-core stack, counters, group store and result register.
`timescale 1ns / 1ps

module gfbs_dp #(
   parameter int GROUP_SIZE = 16,
   parameter int NUM_BLOCKS = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_type,
   input  logic [gfbs_pkg::BLK_W-1:0]        req_block_num,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gfbs_pkg::BLK_W-1:0]        rsp_alloc_block,
   output logic [gfbs_pkg::STATUS_W-1:0]     rsp_status,
   input  gfbs_pkg::cmd_type                 cmd,
   output gfbs_pkg::sts_type                 sts
);

   localparam int BW     = gfbs_pkg::BLK_W;
   localparam int TOP_W  = $clog2(GROUP_SIZE + 1);
   localparam int IDX_W  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int ROW_W  = GROUP_SIZE * BW;

   localparam logic [TOP_W-1:0] TOP_FULL  = TOP_W'(GROUP_SIZE);
   localparam logic [TOP_W-1:0] TOP_ONE   = TOP_W'(1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(NUM_BLOCKS);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [BW:0]      BLK_LIMIT = (BW + 1)'(NUM_BLOCKS);

   // Captured request.
   logic          req_type_ff;
   logic [BW-1:0] blk_ff;

   // In-core stack and counters.
   logic [BW-1:0]    ent_ff [GROUP_SIZE];
   logic [TOP_W-1:0] top_ff;
   logic [CNT_W-1:0] cnt_ff;

   // Group store: one row of GROUP_SIZE entries per block number.
   logic [ROW_W-1:0] mem [NUM_BLOCKS];
   logic [ROW_W-1:0] rd_data_ff;
   logic             zero_row_ff;

   // Result register.
   logic                          rsp_valid_ff;
   logic [BW-1:0]                 rsp_blk_ff;
   logic [gfbs_pkg::STATUS_W-1:0] rsp_status_ff;

   // Decode of the captured request against the current state.
   logic             is_alloc;
   logic             push_reject;
   logic             pop_reject;
   logic             pop_last;
   logic             pop_reload;
   logic             spill;
   logic [IDX_W-1:0] top_idx;
   logic [IDX_W-1:0] pop_idx;
   logic [TOP_W-1:0] top_dec;
   logic [BW-1:0]    pop_value;
   logic [ROW_W-1:0] row_wr;
   logic             reload_in_range;

   always_comb begin
      is_alloc    = (req_type_ff == gfbs_pkg::REQ_ALLOC);
      push_reject = (cnt_ff >= CNT_FULL) || ({1'b0, blk_ff} >= BLK_LIMIT);
      pop_reject  = (cnt_ff == '0) || (top_ff == '0) || (top_ff > TOP_FULL);
      pop_last    = (cnt_ff == CNT_ONE);
      pop_reload  = !pop_last && (top_ff == TOP_ONE);
      spill       = (top_ff >= TOP_FULL);
      top_dec     = top_ff - TOP_ONE;
      top_idx     = top_ff[IDX_W-1:0];
      pop_idx     = top_dec[IDX_W-1:0];
      pop_value   = ent_ff[pop_idx];
      reload_in_range = ({1'b0, ent_ff[0]} < BLK_LIMIT);
   end

   // Pack the stack into one row for a spill.
   always_comb begin
      for (int i = 0; i < GROUP_SIZE; i++) begin
         row_wr[i*BW +: BW] = ent_ff[i];
      end
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign sts.reload   = is_alloc && !pop_reject && pop_reload;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         blk_ff      <= req_block_num;
      end
   end

   // Stack pointer and free counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.execute) begin
         if (!is_alloc) begin
            if (!push_reject) begin
               top_ff <= spill ? TOP_ONE : top_ff + TOP_ONE;
               cnt_ff <= cnt_ff + CNT_ONE;
            end
         end else if (!pop_reject) begin
            if (pop_last) begin
               top_ff <= '0;
               cnt_ff <= '0;
            end else if (pop_reload) begin
               top_ff <= TOP_FULL;
               cnt_ff <= cnt_ff - CNT_ONE;
            end else begin
               top_ff <= top_dec;
               cnt_ff <= cnt_ff - CNT_ONE;
            end
         end
      end
   end

   // Stack entries: a push writes one entry, a reload writes them all.
   always_ff @(posedge clock) begin
      if (cmd.execute && !is_alloc && !push_reject) begin
         if (spill) begin
            ent_ff[0] <= blk_ff;
         end else begin
            ent_ff[top_idx] <= blk_ff;
         end
      end else if (cmd.load) begin
         for (int i = 0; i < GROUP_SIZE; i++) begin
            ent_ff[i] <= zero_row_ff ? '0 : rd_data_ff[i*BW +: BW];
         end
      end
   end

   // Group store: spill write and registered reload read.
   always_ff @(posedge clock) begin
      if (cmd.execute && !is_alloc && !push_reject && spill) begin
         mem[blk_ff[ADDR_W-1:0]] <= row_wr;
      end
      if (cmd.execute && sts.reload) begin
         zero_row_ff <= !reload_in_range;
         if (reload_in_range) begin
            rd_data_ff <= mem[ent_ff[0][ADDR_W-1:0]];
         end
      end
   end

   // Result register: held until the transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (!is_alloc) begin
            rsp_blk_ff    <= '0;
            rsp_status_ff <= push_reject ? gfbs_pkg::ST_FULL : gfbs_pkg::ST_OK;
         end else if (pop_reject) begin
            rsp_blk_ff    <= '0;
            rsp_status_ff <= gfbs_pkg::ST_EMPTY;
         end else begin
            rsp_blk_ff    <= pop_value;
            rsp_status_ff <= gfbs_pkg::ST_OK;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alloc_block = rsp_blk_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

### src/grouped_free_block_stack.sv
// A request is captured, then applied and its result registered once the result register is free,
// reloads included. The next request is taken only after the previous one is applied and any
// stack reload from the registered read of the group store row is done.
// A finished result waits in its output register while the next request is taken.
// Reset clears the stack pointer, the free count and both channels; the group store is
// left unwritten and needs no clearing.
`timescale 1ns / 1ps

module grouped_free_block_stack #(
   parameter int GROUP_SIZE = 16,
   parameter int NUM_BLOCKS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [gfbs_pkg::BLK_W-1:0]    req_block_num,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gfbs_pkg::BLK_W-1:0]    rsp_alloc_block,
   output logic [gfbs_pkg::STATUS_W-1:0] rsp_status
);

   gfbs_pkg::cmd_type cmd;
   gfbs_pkg::sts_type sts;

   // Request sequencing.
   gfbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Stack, counters, group store and result register.
   gfbs_dp #(
      .GROUP_SIZE (GROUP_SIZE),
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_block_num   (req_block_num),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_alloc_block (rsp_alloc_block),
      .rsp_status      (rsp_status),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

### dv/grouped_free_block_stack_checker.sv
// Checker for the grouped free-block stack: predicts each result and compares transfers.
`timescale 1ns / 1ps

module grouped_free_block_stack_checker #(
   parameter int GROUP_SIZE = 16,
   parameter int NUM_BLOCKS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_type,
   input  logic [gfbs_pkg::BLK_W-1:0]    req_block_num,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [gfbs_pkg::BLK_W-1:0]    rsp_alloc_block,
   input  logic [gfbs_pkg::STATUS_W-1:0] rsp_status,
   output int                            failure_count,
   output int                            results_pending
);

   localparam int BLK_W    = gfbs_pkg::BLK_W;
   localparam int STATUS_W = gfbs_pkg::STATUS_W;

   typedef struct packed {
      logic [BLK_W-1:0]    alloc_block;
      logic [STATUS_W-1:0] status;
   } alloc_result_type;

   // Shadow copy of the allocator state.
   logic [BLK_W-1:0] group_rows [0:NUM_BLOCKS*GROUP_SIZE-1];
   logic [BLK_W-1:0] core_stack [0:GROUP_SIZE-1];
   int               stack_depth;
   int               blocks_free;

   alloc_result_type expected_results[$];
   alloc_result_type oldest_result;

   // Apply one request to the shadow state and return the result it should produce.
   function alloc_result_type predict_request(input logic kind, input logic [BLK_W-1:0] blk);
      alloc_result_type res;
      int               i;
      res.alloc_block = '0;
      res.status      = gfbs_pkg::ST_OK;
      if (kind == gfbs_pkg::REQ_FREE) begin
         if (blocks_free >= NUM_BLOCKS || int'(blk) >= NUM_BLOCKS) begin
            res.status = gfbs_pkg::ST_FULL;
         end else begin
            // A full stack spills into the row named by the freed block.
            if (stack_depth >= GROUP_SIZE) begin
               for (i = 0; i < GROUP_SIZE; i++)
                  group_rows[int'(blk) * GROUP_SIZE + i] = core_stack[i];
               stack_depth = 0;
            end
            core_stack[stack_depth] = blk;
            stack_depth++;
            blocks_free++;
         end
      end else begin
         if (blocks_free == 0 || stack_depth == 0 || stack_depth > GROUP_SIZE) begin
            res.status = gfbs_pkg::ST_EMPTY;
         end else if (blocks_free == 1) begin
            // The last free block leaves without a reload.
            res.alloc_block = core_stack[stack_depth-1];
            stack_depth     = 0;
            blocks_free     = 0;
         end else if (stack_depth == 1) begin
            // The bottom entry names the row that refills the stack.
            res.alloc_block = core_stack[0];
            for (i = 0; i < GROUP_SIZE; i++)
               core_stack[i] = (int'(res.alloc_block) < NUM_BLOCKS) ?
                               group_rows[int'(res.alloc_block) * GROUP_SIZE + i] : '0;
            stack_depth = GROUP_SIZE;
            blocks_free--;
         end else begin
            stack_depth--;
            res.alloc_block = core_stack[stack_depth];
            blocks_free--;
         end
      end
      return res;
   endfunction

   // Compare each result transfer with the oldest prediction, then log new requests.
   always @(posedge clock) begin
      if (reset) begin
         stack_depth = 0;
         blocks_free = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transfer: alloc_block %0d, status %0d",
                      rsp_alloc_block, rsp_status);
               failure_count++;
            end else begin
               oldest_result = expected_results.pop_front();
               if (oldest_result.alloc_block !== rsp_alloc_block) begin
                  $error("alloc_block mismatch: expected %0d, actual %0d",
                         oldest_result.alloc_block, rsp_alloc_block);
                  failure_count++;
               end
               if (oldest_result.status !== rsp_status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         oldest_result.status, rsp_status);
                  failure_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(predict_request(req_type, req_block_num));
      end
      results_pending = expected_results.size();
   end

endmodule

### dv/grouped_free_block_stack_test.sv
// Top of the grouped free-block stack testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module grouped_free_block_stack_test;

   localparam int BLK_W    = gfbs_pkg::BLK_W;
   localparam int STATUS_W = gfbs_pkg::STATUS_W;

   // The block in its default configuration.
   localparam int GROUP_SIZE = 16;
   localparam int NUM_BLOCKS = 4096;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_type;
   logic [BLK_W-1:0]    req_block_num;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [BLK_W-1:0]    rsp_alloc_block;
   logic [STATUS_W-1:0] rsp_status;

   int failure_count;
   int results_pending;
   int items_sent;
   bit pressure_done;
   bit sender_quiet;

   grouped_free_block_stack #(
      .GROUP_SIZE(GROUP_SIZE),
      .NUM_BLOCKS(NUM_BLOCKS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_block_num   (req_block_num),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_alloc_block (rsp_alloc_block),
      .rsp_status      (rsp_status)
   );

   grouped_free_block_stack_checker #(
      .GROUP_SIZE(GROUP_SIZE),
      .NUM_BLOCKS(NUM_BLOCKS)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_block_num   (req_block_num),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_alloc_block (rsp_alloc_block),
      .rsp_status      (rsp_status),
      .failure_count   (failure_count),
      .results_pending (results_pending)
   );

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 40);
   endfunction

   // Offer one request from a falling edge and return at the falling edge after its transfer.
   task automatic send_request(input logic kind, input logic [BLK_W-1:0] blk);
      int gap;
      gap = sender_quiet ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_block_num <= blk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic free_block(input logic [BLK_W-1:0] blk);
      send_request(gfbs_pkg::REQ_FREE, blk);
   endtask

   task automatic alloc_block();
      send_request(gfbs_pkg::REQ_ALLOC, BLK_W'($urandom_range(0, 4095)));
   endtask

   // A freed block number, usually within the pool and sometimes anywhere in the field.
   function automatic logic [BLK_W-1:0] pick_block();
      if ($urandom_range(0, 9) == 0)
         return BLK_W'($urandom_range(0, 4095));
      else
         return BLK_W'($urandom_range(0, NUM_BLOCKS-1));
   endfunction

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver stalls, including one long hold-off that backs the block up.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (!pressure_done && items_sent >= 400) begin
            hold          = 80;
            pressure_done = 1'b1;
         end else begin
            hold = idle_cycles();
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(10, 40)) @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      int i;
      int n;
      int seg_len;
      int push_pct;
      int random_sent;
      req_valid     = 1'b0;
      req_type      = gfbs_pkg::REQ_FREE;
      req_block_num = '0;
      reset         = 1'b1;
      sender_quiet  = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: allocate from an empty pool, the last free block, a free of the top number.
      alloc_block();
      free_block('0);
      alloc_block();
      free_block(BLK_W'(4095));
      // Fill the stack, spill it into a row, then pop through the reload.
      free_block(BLK_W'(NUM_BLOCKS-1));
      for (i = 1; i < GROUP_SIZE; i++)
         free_block(BLK_W'(i));
      free_block(BLK_W'(64));
      alloc_block();
      alloc_block();

      // A long run of frees that spills the stack several times.
      for (i = 0; i < 140; i++)
         free_block(BLK_W'($urandom_range(0, NUM_BLOCKS-1)));

      // Random segments, each with its own mix of frees and allocates.
      random_sent = 0;
      while (random_sent < 900) begin
         case ($urandom_range(0, 4))
            0: push_pct = 95;
            1: push_pct = 70;
            2: push_pct = 50;
            3: push_pct = 30;
            default: push_pct = 5;
         endcase
         seg_len      = $urandom_range(20, 100);
         sender_quiet = ($urandom_range(0, 3) == 0);
         for (n = 0; n < seg_len; n++) begin
            if ($urandom_range(0, 99) < push_pct)
               free_block(pick_block());
            else
               alloc_block();
         end
         random_sent += seg_len;
      end
      sender_quiet = 1'b0;
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray transfer.
      while (results_pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (failure_count == 0)
         $display("grouped_free_block_stack_test: done, clean");
      else
         $display("grouped_free_block_stack_test: done, errors");
      $finish;
   end

   // Run limit.
   initial begin
      #10_000_000;
      $display("grouped_free_block_stack_test: done, errors");
      $finish;
   end

endmodule

### sim.f
src/gfbs_pkg.sv
src/gfbs_ctrl.sv
src/gfbs_dp.sv
src/grouped_free_block_stack.sv
dv/grouped_free_block_stack_checker.sv
dv/grouped_free_block_stack_test.sv
